// File: rtl/core/wspd_pkg.sv
// ----------------------------------------------------------------------------
// wspd_pkg
// types, constants and helpers shared by the wav stream parse/decode block
// ----------------------------------------------------------------------------
package wspd_pkg;

   localparam logic [31:0] ID_RIFF  = 32'h4646_4952;
   localparam logic [31:0] ID_WAVE  = 32'h4556_4157;
   localparam logic [31:0] ID_FMT   = 32'h2074_6D66;
   localparam logic [31:0] ID_DATA  = 32'h6174_6164;
   localparam logic [31:0] MIN_FILE = 32'd44;
   localparam int unsigned QUEUE_DEPTH = 4;

   // audio format codes accepted in the fmt chunk
   localparam logic [15:0] FMT_PCM   = 16'd1;
   localparam logic [15:0] FMT_FLOAT = 16'd3;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_CHDR   = 3'd1,
      PH_FMT    = 3'd2,
      PH_SKIP   = 3'd3,
      PH_PAD    = 3'd4,
      PH_DATA   = 3'd5,
      PH_DONE   = 3'd6,
      PH_HALT   = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      KIND_FORMAT = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_NO_RIFF   = 3'd2;
   localparam logic [2:0] ST_NO_WAVE   = 3'd3;
   localparam logic [2:0] ST_BAD_FMT   = 3'd4;
   localparam logic [2:0] ST_NO_FMT    = 3'd5;
   localparam logic [2:0] ST_NO_DATA   = 3'd6;
   localparam logic [2:0] ST_BAD_WIDTH = 3'd7;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       first_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [23:0] sample;
      logic [15:0]        channels;
      logic [31:0]        sample_rate;
      logic [15:0]        bits_per_sample;
      logic               is_float;
      logic [31:0]        data_offset;
      logic [31:0]        data_bytes;
      logic [2:0]         status;
      logic               last;
   } rsp_type;

   // classified work for the back part: up to one event result plus final status
   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_FORMAT = 2'd1,
      EV_WORD   = 2'd2,
      EV_ERROR  = 2'd3
   } event_type;

   typedef struct packed {
      event_type   ev;
      logic [31:0] word;
      logic [1:0]  nb;
      logic [2:0]  code;
      logic [15:0] channels;
      logic [31:0] sample_rate;
      logic [15:0] bits_per_sample;
      logic        is_float;
      logic [31:0] data_offset;
      logic [31:0] data_bytes;
      logic        fin;
      logic [2:0]  fin_status;
   } work_type;

   function automatic logic [23:0] float_to_q23(input logic [31:0] w);
      logic [7:0]  e;
      logic [22:0] m;
      logic [7:0]  sh;
      logic [23:0] mag;
      e = w[30:23];
      m = w[22:0];
      sh = 8'd127 - e;
      mag = '0;
      if (e == 8'hFF && m != '0) begin
         float_to_q23 = '0;
      end else if (e >= 8'd127) begin
         float_to_q23 = w[31] ? 24'h80_0000 : 24'h7F_FFFF;
      end else if (e == 8'd0) begin
         float_to_q23 = '0;
      end else begin
         if (sh < 8'd24) begin
            mag = {1'b1, m} >> sh[4:0];
         end
         float_to_q23 = w[31] ? (24'd0 - mag) : mag;
      end
   endfunction

endpackage

// File: rtl/core/wspd_front.sv
// ----------------------------------------------------------------------------
// wspd_front
// byte walker: tracks riff/chunk structure and classifies each request
// ----------------------------------------------------------------------------
module wspd_front
   import wspd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  req_type  in_req,
   output logic     in_take,
   input  logic     q_full,
   output logic     wr_en,
   output work_type wr_work
);

   phase_type   phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] id_ff, id_in;
   logic [31:0] clen_ff, clen_in;
   logic [31:0] left_ff, left_in;
   logic        pad_ff, pad_in;
   logic        fseen_ff, fseen_in;
   logic [15:0] fcode_ff, fcode_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] width_ff, width_in;
   logic [31:0] asm_ff, asm_in;
   logic [1:0]  idx_ff, idx_in;
   logic [2:0]  err_ff, err_in;

   assign in_take = in_valid && !q_full;
   assign wr_en   = in_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         count_ff <= '0; id_ff <= '0; clen_ff <= '0; left_ff <= '0;
         pad_ff <= 1'b0; fseen_ff <= 1'b0; fcode_ff <= '0; chan_ff <= '0;
         rate_ff <= '0; width_ff <= '0; asm_ff <= '0; idx_ff <= '0; err_ff <= '0;
      end else if (in_take) begin
         phase_ff <= phase_in;
         count_ff <= count_in; id_ff <= id_in; clen_ff <= clen_in; left_ff <= left_in;
         pad_ff <= pad_in; fseen_ff <= fseen_in; fcode_ff <= fcode_in; chan_ff <= chan_in;
         rate_ff <= rate_in; width_ff <= width_in; asm_ff <= asm_in; idx_ff <= idx_in;
         err_ff <= err_in;
      end
   end

   always_comb begin
      logic [7:0]  b;
      logic [31:0] pos;
      logic [31:0] off;
      logic [31:0] left_dec;
      logic [2:0]  nbw;
      logic [31:0] asm_new;
      b = in_req.file_byte;
      phase_in = phase_ff;
      count_in = count_ff; id_in = id_ff; clen_in = clen_ff; left_in = left_ff;
      pad_in = pad_ff; fseen_in = fseen_ff; fcode_in = fcode_ff; chan_in = chan_ff;
      rate_in = rate_ff; width_in = width_ff; asm_in = asm_ff; idx_in = idx_ff;
      err_in = err_ff;
      if (in_req.first_byte) begin
         phase_in = PH_HEADER;
         count_in = '0; id_in = '0; clen_in = '0; left_in = '0;
         pad_in = 1'b0; fseen_in = 1'b0; fcode_in = '0; chan_in = '0;
         rate_in = '0; width_in = '0; asm_in = '0; idx_in = '0; err_in = '0;
      end
      pos = count_in;
      if (count_in != 32'hFFFF_FFFF) begin
         count_in = count_in + 32'd1;
      end
      left_dec = left_in - 32'd1;
      off = clen_in - left_in;
      nbw = width_in[5:3];
      asm_new = '0;

      wr_work = '0;
      wr_work.ev = EV_NONE;
      wr_work.nb = nbw[1:0];

      case (phase_in)
         PH_HEADER: begin
            id_in = {b, id_in[31:8]};
            if (pos == 32'd3 && id_in != ID_RIFF) begin
               wr_work.ev = EV_ERROR; wr_work.code = ST_NO_RIFF;
               err_in = ST_NO_RIFF; phase_in = PH_HALT;
            end else if (pos == 32'd11) begin
               if (id_in != ID_WAVE) begin
                  wr_work.ev = EV_ERROR; wr_work.code = ST_NO_WAVE;
                  err_in = ST_NO_WAVE; phase_in = PH_HALT;
               end else begin
                  phase_in = PH_CHDR; left_in = 32'd8;
               end
            end
         end
         PH_CHDR: begin
            if (left_in > 32'd4) begin
               id_in = {b, id_in[31:8]};
            end else begin
               clen_in = {b, clen_in[31:8]};
            end
            left_in = left_dec;
            if (left_dec == '0) begin
               // chunk header complete
               pad_in = clen_in[0];
               left_in = clen_in;
               if (id_in == ID_FMT) begin
                  fcode_in = '0; chan_in = '0; rate_in = '0; width_in = '0;
                  phase_in = PH_FMT;
                  if (clen_in == '0) begin
                     wr_work.ev = EV_ERROR; wr_work.code = ST_BAD_FMT;
                     err_in = ST_BAD_FMT; phase_in = PH_HALT;
                  end
               end else if (id_in == ID_DATA) begin
                  if (!fseen_in) begin
                     wr_work.ev = EV_ERROR; wr_work.code = ST_NO_FMT;
                     err_in = ST_NO_FMT; phase_in = PH_HALT;
                  end else if (width_in != 16'd8 && width_in != 16'd16 &&
                               width_in != 16'd24 && width_in != 16'd32) begin
                     wr_work.ev = EV_ERROR; wr_work.code = ST_BAD_WIDTH;
                     err_in = ST_BAD_WIDTH; phase_in = PH_HALT;
                  end else begin
                     wr_work.ev = EV_FORMAT;
                     wr_work.channels = chan_in;
                     wr_work.sample_rate = rate_in;
                     wr_work.bits_per_sample = width_in;
                     wr_work.is_float = (fcode_in == FMT_FLOAT);
                     wr_work.data_offset = count_in;
                     wr_work.data_bytes = clen_in;
                     asm_in = '0; idx_in = '0;
                     phase_in = (clen_in == '0) ? PH_DONE : PH_DATA;
                  end
               end else begin
                  phase_in = PH_SKIP;
                  if (clen_in == '0) begin
                     if (pad_in) begin
                        phase_in = PH_PAD;
                     end else begin
                        phase_in = PH_CHDR; left_in = 32'd8;
                     end
                  end
               end
            end
         end
         PH_FMT: begin
            if (off < 32'd2) begin
               fcode_in = fcode_in | (16'(b) << {off[0], 3'b000});
            end else if (off < 32'd4) begin
               chan_in = chan_in | (16'(b) << {off[0], 3'b000});
            end else if (off < 32'd8) begin
               rate_in = rate_in | (32'(b) << {off[1:0], 3'b000});
            end else if (off == 32'd14 || off == 32'd15) begin
               width_in = width_in | (16'(b) << {off[0], 3'b000});
            end
            left_in = left_dec;
            if (left_dec == '0) begin
               if (fcode_in != FMT_PCM && fcode_in != FMT_FLOAT) begin
                  wr_work.ev = EV_ERROR; wr_work.code = ST_BAD_FMT;
                  err_in = ST_BAD_FMT; phase_in = PH_HALT;
               end else begin
                  fseen_in = 1'b1;
                  if (pad_in) begin
                     phase_in = PH_PAD;
                  end else begin
                     phase_in = PH_CHDR; left_in = 32'd8;
                  end
               end
            end
         end
         PH_SKIP: begin
            left_in = left_dec;
            if (left_dec == '0) begin
               if (pad_in) begin
                  phase_in = PH_PAD;
               end else begin
                  phase_in = PH_CHDR; left_in = 32'd8;
               end
            end
         end
         PH_PAD: begin
            pad_in = 1'b0;
            phase_in = PH_CHDR; left_in = 32'd8;
         end
         PH_DATA: begin
            asm_new = asm_in | (32'(b) << {idx_in, 3'b000});
            if ({1'b0, idx_in} + 3'd1 >= nbw) begin
               wr_work.ev = EV_WORD;
               wr_work.word = asm_new;
               asm_in = '0; idx_in = '0;
            end else begin
               asm_in = asm_new; idx_in = idx_in + 2'd1;
            end
            left_in = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_DONE;
            end
         end
         default: begin
         end
      endcase

      if (in_req.final_byte) begin
         wr_work.fin = 1'b1;
         if (count_in < MIN_FILE) begin
            wr_work.fin_status = ST_SHORT;
         end else if (phase_in == PH_HALT) begin
            wr_work.fin_status = err_in;
         end else if (phase_in == PH_DATA || phase_in == PH_DONE) begin
            wr_work.fin_status = ST_OK;
         end else if (phase_in == PH_FMT) begin
            wr_work.fin_status = ST_BAD_FMT;
         end else begin
            wr_work.fin_status = ST_NO_DATA;
         end
         phase_in = PH_HEADER;
         count_in = '0; id_in = '0; clen_in = '0; left_in = '0;
         pad_in = 1'b0; fseen_in = 1'b0; fcode_in = '0; chan_in = '0;
         rate_in = '0; width_in = '0; asm_in = '0; idx_in = '0; err_in = '0;
      end
   end

endmodule

// File: rtl/core/wspd_queue.sv
// ----------------------------------------------------------------------------
// wspd_queue
// short fifo between the front walker and the back emitter
// ----------------------------------------------------------------------------
module wspd_queue
   import wspd_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  work_type wr_work,
   output logic     full,
   input  logic     rd_en,
   output logic     not_empty,
   output work_type rd_work
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   work_type          mem_ff [DEPTH];
   logic [AW-1:0]     wp_ff, rp_ff;
   logic [AW:0]       cnt_ff;

   assign full      = (cnt_ff == (AW+1)'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign rd_work   = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wp_ff] <= wr_work;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr_en) begin
            wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + AW'(1);
         end
         if (rd_en) begin
            rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + AW'(1);
         end
         cnt_ff <= cnt_ff + (AW+1)'(wr_en) - (AW+1)'(rd_en);
      end
   end

endmodule

// File: rtl/core/wspd_back.sv
// ----------------------------------------------------------------------------
// wspd_back
// result emitter: decodes sample words and sends event and final status
// ----------------------------------------------------------------------------
module wspd_back
   import wspd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     q_not_empty,
   input  work_type q_work,
   output logic     q_pop,
   output logic     out_valid,
   output rsp_type  out_rsp,
   input  logic     out_stall
);

   // set once the event result of the head entry has gone out
   logic    ev_done_ff, ev_done_in;
   logic    valid_ff, valid_in;
   rsp_type rsp_ff, rsp_in;

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_done_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         ev_done_ff <= ev_done_in;
         valid_ff   <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   always_comb begin
      logic has_ev;
      logic slot_free;
      logic [23:0] s;
      has_ev = (q_work.ev != EV_NONE) && !ev_done_ff;
      slot_free = !valid_ff || !out_stall;
      valid_in = valid_ff && out_stall;
      rsp_in = rsp_ff;
      ev_done_in = ev_done_ff;
      q_pop = 1'b0;
      s = '0;
      case (q_work.nb)
         2'd1:    s = {q_work.word[7:0] ^ 8'h80, 16'h0000};
         2'd2:    s = {q_work.word[15:0], 8'h00};
         2'd3:    s = q_work.word[23:0];
         default: s = float_to_q23(q_work.word);
      endcase
      if (slot_free && q_not_empty) begin
         if (has_ev || !q_work.fin) begin
            valid_in = (q_work.ev != EV_NONE);
            rsp_in = '0;
            case (q_work.ev)
               EV_FORMAT: begin
                  rsp_in.kind = KIND_FORMAT;
                  rsp_in.channels = q_work.channels;
                  rsp_in.sample_rate = q_work.sample_rate;
                  rsp_in.bits_per_sample = q_work.bits_per_sample;
                  rsp_in.is_float = q_work.is_float;
                  rsp_in.data_offset = q_work.data_offset;
                  rsp_in.data_bytes = q_work.data_bytes;
               end
               EV_WORD: begin
                  rsp_in.kind = KIND_SAMPLE;
                  rsp_in.sample = s;
               end
               EV_ERROR: begin
                  rsp_in.kind = KIND_STATUS;
                  rsp_in.status = q_work.code;
               end
               default: begin
               end
            endcase
            rsp_in.last = !q_work.fin;
            if (q_work.fin) begin
               ev_done_in = 1'b1;
            end else begin
               q_pop = 1'b1;
            end
         end else begin
            valid_in = 1'b1;
            rsp_in = '0;
            rsp_in.kind = KIND_STATUS;
            rsp_in.status = q_work.fin_status;
            rsp_in.last = 1'b1;
            q_pop = 1'b1;
            ev_done_in = 1'b0;
         end
      end
   end

endmodule

// File: rtl/core/wav_stream_parse_decode_unit.sv
// ----------------------------------------------------------------------------
// wav_stream_parse_decode_unit
// streaming riff/wave parser with pcm and float sample decode to q1.23
// ----------------------------------------------------------------------------
//  channel | direction | payload  | flow
//  req_    | in        | req_type | valid / stall
//  rsp_    | out       | rsp_type | valid / stall
//
// one byte is taken per cycle while the front/back queue has room
// the back part sends one result per cycle while rsp_ is not stalled; a byte
// with an event and a final status gives the event, then the status
// req_stall rises only when the queue is full, behind a stalled rsp_ or a
// run of bytes that each give two results
// reset clears walker state and the queue; no clearing pass
// ----------------------------------------------------------------------------
module wav_stream_parse_decode_unit
   import wspd_pkg::*;
#(
   parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   logic     take, q_full, wr_en, q_ne, q_pop;
   work_type wr_work, rd_work;

   assign req_stall = q_full;

   wspd_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_req(req_data),
      .in_take(take), .q_full(q_full), .wr_en(wr_en), .wr_work(wr_work)
   );

   wspd_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock(clock), .reset(reset), .wr_en(wr_en && take), .wr_work(wr_work),
      .full(q_full), .rd_en(q_pop), .not_empty(q_ne), .rd_work(rd_work)
   );

   wspd_back u_back (
      .clock(clock), .reset(reset), .q_not_empty(q_ne), .q_work(rd_work),
      .q_pop(q_pop), .out_valid(rsp_valid), .out_rsp(rsp_data), .out_stall(rsp_stall)
   );

endmodule

// File: rtl/core/wspd_checker.sv
// ----------------------------------------------------------------------------
// wspd_checker
// port-level checks for the wav stream parse/decode unit
// ----------------------------------------------------------------------------
module wspd_checker
   import wspd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input req_type req_data,
   input logic    req_stall,
   input logic    rsp_valid,
   input rsp_type rsp_data,
   input logic    rsp_stall
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.kind == KIND_FORMAT || rsp_data.kind == KIND_SAMPLE ||
      rsp_data.kind == KIND_STATUS)
      else $error("bad result kind");

   a_sample_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_SAMPLE |-> rsp_data.sample == '0)
      else $error("sample set on non-sample result");

   a_fmt_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_FORMAT |->
      rsp_data.bits_per_sample == 16'd8 || rsp_data.bits_per_sample == 16'd16 ||
      rsp_data.bits_per_sample == 16'd24 || rsp_data.bits_per_sample == 16'd32)
      else $error("format result with bad width");

endmodule

bind wav_stream_parse_decode_unit wspd_checker u_wspd_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_data(req_data),
   .req_stall(req_stall), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
   .rsp_stall(rsp_stall)
);

// File: tb/wav_stream_parse_decode_unit_tb.sv
// ----------------------------------------------------------------------------
// wav_stream_parse_decode_unit_tb
// drives byte streams of well-formed and broken wav files into the parser,
// predicts format, sample and status results in a scoreboard and compares
// every result field by field, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module wav_stream_parse_decode_unit_tb;
   import wspd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   class wav_scoreboard;
      phase_type   phase;
      logic [31:0] nbytes, id_shift, chunk_len, remaining;
      logic        pad_due, have_fmt;
      logic [15:0] fmt_code, chans, width;
      logic [31:0] rate, word;
      logic [1:0]  word_idx;
      logic [2:0]  err;
      rsp_type     pending[$];
      rsp_type     step_rsps[$];
      int          fails;

      function void clear_state();
         phase = PH_HEADER; nbytes = 0; id_shift = 0; chunk_len = 0; remaining = 0;
         pad_due = 0; have_fmt = 0; fmt_code = 0; chans = 0; rate = 0; width = 0;
         word = 0; word_idx = 0; err = 0;
      endfunction

      function void emit(kind_type k, logic [23:0] smp, logic [2:0] st, bit with_fmt);
         rsp_type r;
         r = '0;
         r.kind = k;
         r.sample = smp;
         if (with_fmt) begin
            r.channels = chans; r.sample_rate = rate; r.bits_per_sample = width;
            r.is_float = (fmt_code == FMT_FLOAT); r.data_offset = nbytes;
            r.data_bytes = chunk_len;
         end
         r.status = st;
         step_rsps = {step_rsps, r};
      endfunction

      function void halt(logic [2:0] code);
         err = code; phase = PH_HALT;
         emit(KIND_STATUS, '0, code, 0);
      endfunction

      function void body_done();
         if (pad_due) phase = PH_PAD;
         else begin phase = PH_CHDR; remaining = 8; end
      endfunction

      function void fmt_done();
         if (fmt_code != FMT_PCM && fmt_code != FMT_FLOAT) halt(ST_BAD_FMT);
         else begin have_fmt = 1; body_done(); end
      endfunction

      function logic [23:0] q23_of(logic [31:0] w);
         logic [7:0]  e;
         logic [23:0] mag;
         e = w[30:23];
         if (e == 8'hFF && w[22:0] != 0) return '0;
         if (e >= 8'd127) return w[31] ? 24'h800000 : 24'h7FFFFF;
         if (e == 0) return '0;
         mag = (127 - e >= 24) ? 24'd0 : ({1'b1, w[22:0]} >> (127 - e));
         return w[31] ? -mag : mag;
      endfunction

      function void open_chunk();
         pad_due = chunk_len[0];
         remaining = chunk_len;
         if (id_shift == ID_FMT) begin
            fmt_code = 0; chans = 0; rate = 0; width = 0;
            phase = PH_FMT;
            if (remaining == 0) fmt_done();
         end else if (id_shift == ID_DATA) begin
            if (!have_fmt) halt(ST_NO_FMT);
            else if (!(width inside {16'd8, 16'd16, 16'd24, 16'd32})) halt(ST_BAD_WIDTH);
            else begin
               emit(KIND_FORMAT, '0, ST_OK, 1);
               word = 0; word_idx = 0;
               phase = (remaining == 0) ? PH_DONE : PH_DATA;
            end
         end else begin
            phase = PH_SKIP;
            if (remaining == 0) body_done();
         end
      endfunction

      // one accepted request: computes its results and queues them
      function void note_request(req_type q);
         logic [31:0] pos, off;
         logic [2:0]  nb, st;
         logic [23:0] s;
         step_rsps = {};
         if (q.first_byte) clear_state();
         pos = nbytes;
         if (nbytes != 32'hFFFFFFFF) nbytes++;
         case (phase)
            PH_HEADER: begin
               id_shift = {q.file_byte, id_shift[31:8]};
               if (pos == 3 && id_shift != ID_RIFF) halt(ST_NO_RIFF);
               else if (pos == 11) begin
                  if (id_shift != ID_WAVE) halt(ST_NO_WAVE);
                  else begin phase = PH_CHDR; remaining = 8; end
               end
            end
            PH_CHDR: begin
               if (remaining > 4) id_shift = {q.file_byte, id_shift[31:8]};
               else chunk_len = {q.file_byte, chunk_len[31:8]};
               remaining--;
               if (remaining == 0) open_chunk();
            end
            PH_FMT: begin
               off = chunk_len - remaining;
               if (off < 2) fmt_code |= 16'(q.file_byte) << (8 * off);
               else if (off < 4) chans |= 16'(q.file_byte) << (8 * (off - 2));
               else if (off < 8) rate |= 32'(q.file_byte) << (8 * (off - 4));
               else if (off == 14 || off == 15) width |= 16'(q.file_byte) << (8 * (off - 14));
               remaining--;
               if (remaining == 0) fmt_done();
            end
            PH_SKIP: begin
               remaining--;
               if (remaining == 0) body_done();
            end
            PH_PAD: begin
               pad_due = 0; phase = PH_CHDR; remaining = 8;
            end
            PH_DATA: begin
               nb = width[5:3];
               word |= 32'(q.file_byte) << (8 * word_idx);
               if (32'(word_idx) + 1 >= nb) begin
                  case (nb)
                     3'd1: s = {word[7:0] ^ 8'h80, 16'h0};
                     3'd2: s = {word[15:0], 8'h0};
                     3'd3: s = word[23:0];
                     default: s = q23_of(word);
                  endcase
                  emit(KIND_SAMPLE, s, ST_OK, 0);
                  word = 0; word_idx = 0;
               end else word_idx++;
               remaining--;
               if (remaining == 0) phase = PH_DONE;
            end
            default: ;
         endcase
         if (q.final_byte) begin
            if (nbytes < MIN_FILE) st = ST_SHORT;
            else if (phase == PH_HALT) st = err;
            else if (phase == PH_DATA || phase == PH_DONE) st = ST_OK;
            else if (phase == PH_FMT) st = ST_BAD_FMT;
            else st = ST_NO_DATA;
            emit(KIND_STATUS, '0, st, 0);
            clear_state();
         end
         if (step_rsps.size() > 0) step_rsps[$].last = 1;
         foreach (step_rsps[i]) pending = {pending, step_rsps[i]};
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("result with nothing expected: kind %0d", a.kind);
            fails++;
            return;
         end
         e = pending.pop_front();
         if (a.kind !== e.kind) begin
            $error("kind: expected %0d actual %0d", e.kind, a.kind); fails++; end
         if (a.sample !== e.sample) begin
            $error("sample: expected %h actual %h", e.sample, a.sample); fails++; end
         if (a.channels !== e.channels) begin
            $error("channels: expected %0d actual %0d", e.channels, a.channels); fails++; end
         if (a.sample_rate !== e.sample_rate) begin
            $error("sample_rate: expected %0d actual %0d", e.sample_rate, a.sample_rate);
            fails++;
         end
         if (a.bits_per_sample !== e.bits_per_sample) begin
            $error("bits_per_sample: expected %0d actual %0d", e.bits_per_sample,
                   a.bits_per_sample);
            fails++;
         end
         if (a.is_float !== e.is_float) begin
            $error("is_float: expected %0d actual %0d", e.is_float, a.is_float); fails++; end
         if (a.data_offset !== e.data_offset) begin
            $error("data_offset: expected %0d actual %0d", e.data_offset, a.data_offset);
            fails++;
         end
         if (a.data_bytes !== e.data_bytes) begin
            $error("data_bytes: expected %0d actual %0d", e.data_bytes, a.data_bytes);
            fails++;
         end
         if (a.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, a.status); fails++; end
         if (a.last !== e.last) begin
            $error("last: expected %0d actual %0d", e.last, a.last); fails++; end
      endfunction
   endclass

   logic    clock, reset;
   logic    req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_data;
   rsp_type rsp_data;

   wav_scoreboard board;
   int      requests_sent;
   bit      hold_long;

   wav_stream_parse_decode_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_data(req_data), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .rsp_stall(rsp_stall)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // file bytes waiting to be sent: each entry is one request
   req_type file_q[$];

   task automatic add_byte(logic [7:0] b, bit first = 0, bit fin = 0);
      req_type q;
      q.file_byte = b; q.first_byte = first; q.final_byte = fin;
      file_q = {file_q, q};
   endtask

   task automatic add_word(logic [31:0] w, int n);
      for (int i = 0; i < n; i++) add_byte(w[8 * i +: 8]);
   endtask

   // builds one file; fmt_len under 16 gives a short fmt body
   task automatic build_file(logic [15:0] fcode, logic [15:0] bits, int nsamples,
                             int junk_len, bit fmt_first, int fmt_len, bit break_id,
                             int cut);
      req_type img[$];
      int      nb, dlen;
      file_q = {};
      nb = (bits inside {16'd8, 16'd16, 16'd24, 16'd32}) ? bits / 8 : 2;
      dlen = nsamples * nb + $urandom_range(0, 1) * ((nb > 1) ? 1 : 0);
      add_word(break_id ? $urandom : ID_RIFF, 4);
      add_word($urandom, 4);
      add_word(($urandom_range(0, 9) == 0) ? $urandom : ID_WAVE, 4);
      if (junk_len >= 0) begin
         add_word(32'h4B4E554A, 4); add_word(junk_len, 4);
         for (int i = 0; i < junk_len + (junk_len % 2); i++) add_byte($urandom);
      end
      if (fmt_first) begin
         add_word(ID_FMT, 4); add_word(fmt_len, 4);
         for (int i = 0; i < fmt_len + (fmt_len % 2); i++) begin
            case (i)
               0, 1: add_byte(fcode[8 * i +: 8]);
               14, 15: add_byte(bits[8 * (i - 14) +: 8]);
               default: add_byte($urandom);
            endcase
         end
      end
      add_word(ID_DATA, 4); add_word(dlen, 4);
      for (int i = 0; i < dlen; i++) begin
         if (nb == 4 && i % 4 == 3 && $urandom_range(0, 1))
            add_byte({$urandom_range(0, 1) ? 1'b1 : 1'b0, 7'h3F}); // near unity exponent
         else add_byte($urandom);
      end
      if ($urandom_range(0, 3) == 0) add_word($urandom, $urandom_range(1, 4)); // trailing junk
      if (cut > 0 && cut < file_q.size())
         while (file_q.size() > cut) void'(file_q.pop_back());
      file_q[0].first_byte = 1;
      file_q[$].final_byte = 1;
   endtask

   task automatic send_request(req_type q);
      int gap;
      gap = $urandom_range(0, 9) * ($urandom_range(0, 3) != 0);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= q;
      do @(posedge clock); while (req_stall);
      board.note_request(q);
      requests_sent++;
   endtask

   task automatic send_file();
      foreach (file_q[i]) send_request(file_q[i]);
   endtask

   // receiver: a random wait before each result, one long hold-off while the
   // sender keeps going
   initial begin
      int wait_n;
      bit held;
      held = 0;
      rsp_stall = 1;
      @(negedge reset);
      forever begin
         wait_n = $urandom_range(0, 9);
         if (hold_long && !held) begin
            wait_n = 200;
            held = 1;
         end
         if (wait_n > 0) begin
            rsp_stall <= 1;
            repeat (wait_n) @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

   initial begin
      board = new();
      board.clear_state();
      board.fails = 0;
      reset = 1; req_valid = 0; req_data = '0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed files
      build_file(FMT_PCM, 16'd8, 4, -1, 1, 16, 0, 0);         send_file();
      build_file(FMT_PCM, 16'd16, 3, 3, 1, 18, 0, 0);         send_file();
      build_file(FMT_PCM, 16'd24, 2, -1, 1, 16, 0, 0);        send_file();
      build_file(FMT_FLOAT, 16'd32, 3, -1, 1, 16, 0, 0);      send_file();
      build_file(16'd2, 16'd16, 1, -1, 1, 16, 0, 0);          send_file(); // bad format
      build_file(FMT_PCM, 16'd12, 1, -1, 1, 16, 0, 0);        send_file(); // bad width
      build_file(FMT_PCM, 16'd16, 1, -1, 0, 16, 0, 0);        send_file(); // data before fmt
      build_file(FMT_PCM, 16'd16, 1, -1, 1, 16, 1, 0);        send_file(); // no riff
      build_file(FMT_PCM, 16'd16, 1, -1, 1, 10, 0, 0);        send_file(); // short fmt body
      build_file(FMT_PCM, 16'd16, 4, -1, 1, 16, 0, 30);       send_file(); // truncated fmt
      build_file(FMT_PCM, 16'd16, 4, 20, 1, 16, 0, 50);       send_file(); // cut in fmt body, no data chunk
      build_file(FMT_PCM, 16'd16, 1, -1, 1, 16, 0, 5);        send_file(); // short file
      file_q = {};
      add_byte(8'h00, 1, 0); add_byte(8'hFF, 0, 1);                    // tiny file
      send_file(); file_q = {};
      // float corner words
      begin
         logic [31:0] corners[8];
         corners = '{32'h7FC00001, 32'h7F800000, 32'hFF800000, 32'h00000001,
                     32'h3F800000, 32'hBF7FFFFF, 32'h33FFFFFF, 32'hB4000000};
         add_word(ID_RIFF, 4); add_word(32'd76, 4); add_word(ID_WAVE, 4);
         add_word(ID_FMT, 4); add_word(32'd16, 4);
         add_word(32'(FMT_FLOAT), 2); add_word(32'd1, 2); add_word(32'd48000, 4);
         add_word(32'd0, 4); add_word(32'd0, 2); add_word(32'd32, 2);
         add_word(ID_DATA, 4); add_word(32'd32, 4);
         foreach (corners[i]) add_word(corners[i], 4);
         file_q[0].first_byte = 1;
         file_q[$].final_byte = 1;
      end
      send_file();

      // random files, a long receiver hold-off partway through
      while (requests_sent < 1200) begin
         int r;
         r = $urandom_range(0, 19);
         if (requests_sent > 600) hold_long = 1;
         if (r < 14)
            build_file($urandom_range(0, 1) ? FMT_PCM : FMT_FLOAT,
                       16'd8 << $urandom_range(0, 2) + 0,
                       $urandom_range(0, 12), $urandom_range(0, 2) ? -1 : $urandom_range(0, 5),
                       1, $urandom_range(0, 3) ? 16 : $urandom_range(0, 20), 0, 0);
         else if (r < 16)
            build_file(FMT_FLOAT, 16'd32, $urandom_range(1, 8), -1, 1, 16, 0, 0);
         else if (r < 19)
            build_file($urandom, $urandom, $urandom_range(0, 4), $urandom_range(0, 3) - 1,
                       $urandom_range(0, 1), $urandom_range(0, 18), $urandom_range(0, 1),
                       $urandom_range(0, 60));
         else begin
            file_q = {};
            repeat ($urandom_range(1, 50)) add_byte($urandom, $urandom_range(0, 15) == 0);
            file_q[$].final_byte = 1;
         end
         send_file();
      end
      req_valid <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.fails == 0 && board.pending.size() == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
